[rtl/rfp_pkg.sv]
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared types and constants of the response frame parser.
// ----------------------------------------------------------------------------
package rfp_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned StatusWidth = 2;
   localparam int unsigned CsrIdxWidth = 2;

   localparam logic [CsrIdxWidth-1:0] CSR_WANT_STATUS = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_BUF_CAP     = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_FRAME_ID    = 2'd2;

   localparam logic [StatusWidth-1:0] ST_OK   = 2'd0;
   localparam logic [StatusWidth-1:0] ST_COMM = 2'd1;
   localparam logic [StatusWidth-1:0] ST_SIZE = 2'd2;

   localparam logic [ByteWidth-1:0] START_LO  = 8'h00;
   localparam logic [ByteWidth-1:0] START_HI  = 8'hFF;
   localparam logic [ByteWidth-1:0] HUNT_SEED = 8'h55;

   localparam logic [ByteWidth-1:0] RESET_BUF_CAP  = 8'd255;
   localparam logic [ByteWidth-1:0] RESET_FRAME_ID = 8'hD5;

   typedef struct packed {
      logic [ByteWidth-1:0]   data_byte;
      logic [ByteWidth-1:0]   byte_index;
      logic                   is_end;
      logic [StatusWidth-1:0] frame_status;
      logic [ByteWidth-1:0]   device_status;
      logic [ByteWidth-1:0]   payload_length;
   } rsp_item_type;

endpackage

[rtl/rfp_parser.sv]
// ----------------------------------------------------------------------------
// rfp_parser
// Frame state, configuration registers and the per-byte step logic.
// ----------------------------------------------------------------------------
module rfp_parser
   import rfp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [ByteWidth-1:0]   csr_data,
   input  logic                   step,
   input  logic [ByteWidth-1:0]   rx_byte,
   output logic                   res_valid,
   output rsp_item_type           res_item
);

   typedef enum logic [3:0] {
      PH_HUNT = 4'd0,
      PH_LEN  = 4'd1,
      PH_LCS  = 4'd2,
      PH_TFI  = 4'd3,
      PH_CODE = 4'd4,
      PH_STAT = 4'd5,
      PH_DATA = 4'd6,
      PH_DCS  = 4'd7,
      PH_POST = 4'd8
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [ByteWidth-1:0] prev_ff, prev_in;
   logic [ByteWidth-1:0] len_ff, len_in;
   logic [ByteWidth-1:0] left_ff, left_in;
   logic [ByteWidth-1:0] sum_ff, sum_in;
   logic [ByteWidth-1:0] stat_ff, stat_in;

   logic                 want_status_ff;
   logic [ByteWidth-1:0] buf_cap_ff;
   logic [ByteWidth-1:0] frame_id_ff;

   logic                   fin;
   logic [StatusWidth-1:0] fin_status;
   logic [ByteWidth-1:0]   fin_count;
   logic [ByteWidth-1:0]   fin_dev;
   logic                   do_count;
   logic [ByteWidth-1:0]   ck_cnt;
   logic [ByteWidth-1:0]   ck_dev;
   logic [ByteWidth-1:0]   need;
   logic [ByteWidth-1:0]   sum_rx;
   logic [ByteWidth-1:0]   left_dec;

   always_comb begin
      phase_in   = phase_ff;
      prev_in    = prev_ff;
      len_in     = len_ff;
      left_in    = left_ff;
      sum_in     = sum_ff;
      stat_in    = stat_ff;
      fin        = 1'b0;
      fin_status = ST_OK;
      fin_count  = '0;
      fin_dev    = stat_ff;
      do_count   = 1'b0;
      ck_cnt     = left_ff;
      ck_dev     = stat_ff;
      res_valid  = 1'b0;
      res_item   = '0;
      need       = 8'd2 + {7'd0, want_status_ff};
      sum_rx     = sum_ff + rx_byte;
      left_dec   = left_ff - 8'd1;

      case (phase_ff)
         PH_LEN: begin
            len_in   = rx_byte;
            phase_in = PH_LCS;
         end
         PH_LCS: begin
            if ((len_ff + rx_byte) != 8'd0) begin
               fin        = 1'b1;
               fin_status = ST_COMM;
            end else begin
               phase_in = PH_TFI;
            end
         end
         PH_TFI: begin
            if (rx_byte != frame_id_ff) begin
               fin        = 1'b1;
               fin_status = ST_COMM;
            end else begin
               sum_in   = rx_byte;
               phase_in = PH_CODE;
            end
         end
         PH_CODE: begin
            sum_in  = sum_rx;
            stat_in = '0;
            fin_dev = '0;
            if (len_ff < need) begin
               fin        = 1'b1;
               fin_status = ST_COMM;
            end else begin
               left_in = len_ff - need;
               ck_cnt  = len_ff - need;
               ck_dev  = '0;
               if (want_status_ff) begin
                  phase_in = PH_STAT;
               end else begin
                  do_count = 1'b1;
               end
            end
         end
         PH_STAT: begin
            stat_in  = rx_byte;
            sum_in   = sum_rx;
            ck_cnt   = left_ff;
            ck_dev   = rx_byte;
            do_count = 1'b1;
         end
         PH_DATA: begin
            sum_in                  = sum_rx;
            res_valid               = 1'b1;
            res_item.data_byte      = rx_byte;
            res_item.byte_index     = len_ff - left_ff;
            res_item.device_status  = stat_ff;
            res_item.payload_length = len_ff;
            left_in                 = left_dec;
            if (left_dec == 8'd0) begin
               phase_in = PH_DCS;
            end
         end
         PH_DCS: begin
            sum_in = sum_rx;
            if (sum_rx != 8'd0) begin
               fin        = 1'b1;
               fin_status = ST_COMM;
               fin_count  = len_ff;
            end else begin
               phase_in = PH_POST;
            end
         end
         PH_POST: begin
            fin        = 1'b1;
            fin_status = ST_OK;
            fin_count  = len_ff;
         end
         default: begin
            if (rx_byte == START_HI && prev_ff == START_LO) begin
               phase_in = PH_LEN;
            end else begin
               phase_in = PH_HUNT;
               prev_in  = rx_byte;
            end
         end
      endcase

      if (do_count) begin
         if (ck_cnt != 8'd0 && buf_cap_ff < ck_cnt) begin
            fin        = 1'b1;
            fin_status = ST_SIZE;
            fin_count  = ck_cnt;
            fin_dev    = ck_dev;
         end else begin
            len_in   = ck_cnt;
            phase_in = (ck_cnt == 8'd0) ? PH_DCS : PH_DATA;
         end
      end

      if (fin) begin
         res_valid               = 1'b1;
         res_item                = '0;
         res_item.is_end         = 1'b1;
         res_item.frame_status   = fin_status;
         res_item.device_status  = fin_dev;
         res_item.payload_length = fin_count;
         phase_in                = PH_HUNT;
         prev_in                 = HUNT_SEED;
         len_in                  = '0;
         left_in                 = '0;
         sum_in                  = '0;
         stat_in                 = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         prev_ff        <= HUNT_SEED;
         len_ff         <= '0;
         left_ff        <= '0;
         sum_ff         <= '0;
         stat_ff        <= '0;
         want_status_ff <= 1'b0;
         buf_cap_ff     <= RESET_BUF_CAP;
         frame_id_ff    <= RESET_FRAME_ID;
      end else begin
         if (step) begin
            phase_ff <= phase_in;
            prev_ff  <= prev_in;
            len_ff   <= len_in;
            left_ff  <= left_in;
            sum_ff   <= sum_in;
            stat_ff  <= stat_in;
         end
         if (csr_write) begin
            case (csr_index)
               CSR_WANT_STATUS: want_status_ff <= csr_data[0];
               CSR_BUF_CAP:     buf_cap_ff     <= csr_data;
               CSR_FRAME_ID:    frame_id_ff    <= csr_data;
               default: ;
            endcase
         end
      end
   end

endmodule

[rtl/rfp_out_buf.sv]
// ----------------------------------------------------------------------------
// rfp_out_buf
// Result register with a skid stage; ready is registered.
// ----------------------------------------------------------------------------
module rfp_out_buf
   import rfp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_item,
   output logic         can_push,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   logic         main_v_ff;
   logic         skid_v_ff;
   rsp_item_type main_ff;
   rsp_item_type skid_ff;
   logic         pop;

   assign pop       = main_v_ff & rsp_ready;
   assign can_push  = ~skid_v_ff;
   assign rsp_valid = main_v_ff;
   assign rsp_item  = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (!main_v_ff || pop) begin
            if (skid_v_ff) begin
               main_ff   <= skid_ff;
               main_v_ff <= 1'b1;
               skid_v_ff <= 1'b0;
            end else begin
               main_ff   <= push_item;
               main_v_ff <= push;
            end
         end else if (push) begin
            skid_ff   <= push_item;
            skid_v_ff <= 1'b1;
         end
      end
   end

endmodule

[rtl/response_frame_parser_unit.sv]
// ----------------------------------------------------------------------------
// response_frame_parser_unit
// Deframer for length/checksum framed responses, one received byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one received byte per item (valid/ready).
//   rsp_ channel: at most one result item per input byte; payload bytes with
//   their index, and one end item per frame carrying its status.
//   csr_ port: write-only registers, taken at any edge with csr_write high;
//   write them only while the block is idle.
// Timing:
//   A byte is accepted in any cycle with room in the output stage; its
//   result goes to the result register, or to the skid entry if that one is
//   still held. One byte per cycle is sustained while rsp_ready stays high.
// Stall:
//   A result register plus one skid entry; req_ready drops only once the
//   skid entry is occupied, so no item is lost under back-pressure.
// Reset:
//   Synchronous; parser returns to hunting for the start code, registers
//   take their default values and both output entries empty.
// ----------------------------------------------------------------------------
module response_frame_parser_unit
   import rfp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_data_byte,
   output logic [7:0]             rsp_byte_index,
   output logic                   rsp_is_end,
   output logic [1:0]             rsp_frame_status,
   output logic [7:0]             rsp_device_status,
   output logic [7:0]             rsp_payload_length,
   input  logic                   csr_write,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [7:0]             csr_data
);

   logic         step;
   logic         res_valid;
   rsp_item_type res_item;
   rsp_item_type out_item;
   logic         can_push;

   assign req_ready = can_push;
   assign step      = req_valid & can_push;

   rfp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .step      (step),
      .rx_byte   (req_rx_byte),
      .res_valid (res_valid),
      .res_item  (res_item)
   );

   rfp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (step & res_valid),
      .push_item (res_item),
      .can_push  (can_push),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (out_item)
   );

   assign rsp_data_byte      = out_item.data_byte;
   assign rsp_byte_index     = out_item.byte_index;
   assign rsp_is_end         = out_item.is_end;
   assign rsp_frame_status   = out_item.frame_status;
   assign rsp_device_status  = out_item.device_status;
   assign rsp_payload_length = out_item.payload_length;

endmodule

[bench/response_frame_parser_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// response_frame_parser_unit_tb
// Self-checking bench for the response frame parser. Byte items are sent as
// framed responses (good frames, header faults, short LEN, oversized payload,
// bad data checksum) mixed with line noise. The parser is modelled here in
// the bench, and every result item is compared field by field in order.
// Sender bursts and receiver stalls are randomised throughout.
// ----------------------------------------------------------------------------
module response_frame_parser_unit_tb;
   import rfp_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int          RANDOM_ITEMS = 440;

   typedef enum logic [3:0] {
      HUNT_START, GET_LEN, GET_LCS, GET_TFI, GET_CODE,
      GET_STATUS, GET_DATA, GET_DCS, GET_POSTAMBLE
   } parse_phase_type;

   typedef enum int {
      FAULT_NONE, FAULT_LCS, FAULT_TFI, FAULT_SHORT, FAULT_DCS
   } frame_fault_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [7:0]             req_rx_byte;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [7:0]             rsp_data_byte;
   logic [7:0]             rsp_byte_index;
   logic                   rsp_is_end;
   logic [1:0]             rsp_frame_status;
   logic [7:0]             rsp_device_status;
   logic [7:0]             rsp_payload_length;
   logic                   csr_write;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [7:0]             csr_data;

   response_frame_parser_unit dut (.*);

   // parser copy
   parse_phase_type p_phase;
   logic [7:0]   p_prev, p_len, p_left, p_sum, p_status;
   logic         cfg_want;
   logic [7:0]   cfg_cap, cfg_fid;

   rsp_item_type pending_results[$];

   int unsigned cycle_count = 0;
   int          fails = 0;
   int          bytes_sent = 0;
   int          burst_left = 0;
   int          n_data = 0, n_ok = 0, n_comm = 0, n_size = 0, n_frames = 0;
   int          stall_mode = 0, mode_left = 0, hold_left = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("status: fail");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      if (fails < 100)
         $display("[%0t] mismatch: %s", $time, msg);
      fails++;
   endtask

   task automatic back_to_hunt();
      p_phase  = HUNT_START;
      p_prev   = HUNT_SEED;
      p_len    = '0;
      p_left   = '0;
      p_sum    = '0;
      p_status = '0;
   endtask

   task automatic close_frame(input logic [1:0] st, input logic [7:0] count);
      rsp_item_type r;
      r                = '0;
      r.is_end         = 1'b1;
      r.frame_status   = st;
      r.device_status  = p_status;
      r.payload_length = count;
      pending_results.push_back(r);
      back_to_hunt();
   endtask

   task automatic payload_count_known();
      if (p_left != 0 && cfg_cap < p_left) begin
         close_frame(ST_SIZE, p_left);
      end else begin
         p_len   = p_left;
         p_phase = (p_left == 0) ? GET_DCS : GET_DATA;
      end
   endtask

   task automatic parse_byte(input logic [7:0] rx);
      rsp_item_type r;
      logic [7:0]   need;
      case (p_phase)
         GET_LEN: begin
            p_len   = rx;
            p_phase = GET_LCS;
         end
         GET_LCS: begin
            if (8'(p_len + rx) != 8'd0) close_frame(ST_COMM, 8'd0);
            else p_phase = GET_TFI;
         end
         GET_TFI: begin
            if (rx != cfg_fid) begin
               close_frame(ST_COMM, 8'd0);
            end else begin
               p_sum   = rx;
               p_phase = GET_CODE;
            end
         end
         GET_CODE: begin
            p_sum    = p_sum + rx;
            p_status = '0;
            need     = 8'd2 + 8'(cfg_want);
            if (p_len < need) begin
               close_frame(ST_COMM, 8'd0);
            end else begin
               p_left = p_len - need;
               if (cfg_want) p_phase = GET_STATUS;
               else payload_count_known();
            end
         end
         GET_STATUS: begin
            p_status = rx;
            p_sum    = p_sum + rx;
            payload_count_known();
         end
         GET_DATA: begin
            p_sum            = p_sum + rx;
            r                = '0;
            r.data_byte      = rx;
            r.byte_index     = p_len - p_left;
            r.device_status  = p_status;
            r.payload_length = p_len;
            pending_results.push_back(r);
            p_left = p_left - 8'd1;
            if (p_left == 0) p_phase = GET_DCS;
         end
         GET_DCS: begin
            p_sum = p_sum + rx;
            if (p_sum != 8'd0) close_frame(ST_COMM, p_len);
            else p_phase = GET_POSTAMBLE;
         end
         GET_POSTAMBLE: close_frame(ST_OK, p_len);
         default: begin
            if (rx == START_HI && p_prev == START_LO) begin
               p_phase = GET_LEN;
            end else begin
               p_phase = HUNT_START;
               p_prev  = rx;
            end
         end
      endcase
   endtask

   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid   = 1'b1;
      req_rx_byte = b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      parse_byte(b);
      bytes_sent++;
   endtask

   // Sender holds off until every expected result has been taken.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CsrIdxWidth-1:0] idx, input logic [7:0] value);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(negedge clock);
      csr_write = 1'b0;
      case (idx)
         CSR_WANT_STATUS: cfg_want = value[0];
         CSR_BUF_CAP:     cfg_cap  = value;
         CSR_FRAME_ID:    cfg_fid  = value;
         default: ;
      endcase
   endtask

   // One framed response; stops early once the parser has closed the frame.
   task automatic send_frame(input int n, input frame_fault_type fault);
      logic [7:0] len, tfi, dsum, b;
      int         need;
      need = 2 + int'(cfg_want);
      len  = 8'(n + need);
      if (fault == FAULT_SHORT) len = 8'($urandom_range(0, need - 1));
      n_frames++;
      send_byte(START_LO);
      send_byte(START_HI);
      send_byte(len);
      b = 8'd0 - len;
      if (fault == FAULT_LCS) b = b + 8'($urandom_range(1, 255));
      send_byte(b);
      if (p_phase == HUNT_START) return;
      tfi = cfg_fid;
      if (fault == FAULT_TFI) tfi = tfi ^ 8'($urandom_range(1, 255));
      send_byte(tfi);
      if (p_phase == HUNT_START) return;
      b    = 8'($urandom);
      dsum = tfi + b;
      send_byte(b);
      if (p_phase == HUNT_START) return;
      if (cfg_want) begin
         b    = 8'($urandom);
         dsum = dsum + b;
         send_byte(b);
         if (p_phase == HUNT_START) return;
      end
      for (int i = 0; i < n; i++) begin
         b    = 8'($urandom);
         dsum = dsum + b;
         send_byte(b);
      end
      b = 8'd0 - dsum;
      if (fault == FAULT_DCS) b = b + 8'($urandom_range(1, 255));
      send_byte(b);
      if (p_phase == HUNT_START) return;
      send_byte(START_LO);
   endtask

   task automatic test_default_frames();
      send_frame(0, FAULT_NONE);
      send_frame(2, FAULT_NONE);
   endtask

   task automatic test_start_hunting();
      send_byte(START_HI);
      send_byte(START_LO);
      send_byte(START_LO);
      send_frame(1, FAULT_NONE);
   endtask

   task automatic test_header_faults();
      send_frame(0, FAULT_LCS);
      send_frame(0, FAULT_TFI);
      send_frame(0, FAULT_SHORT);
   endtask

   task automatic test_status_and_capacity();
      drain();
      write_csr(CSR_WANT_STATUS, 8'h01);
      write_csr(CSR_BUF_CAP, 8'd2);
      write_csr(CSR_FRAME_ID, 8'h00);
      send_frame(2, FAULT_NONE);
      send_frame(3, FAULT_NONE);
      send_frame(0, FAULT_SHORT);
      drain();
      write_csr(CSR_BUF_CAP, 8'd0);
      send_frame(1, FAULT_NONE);
      send_frame(0, FAULT_NONE);
   endtask

   task automatic test_data_checksum();
      send_frame(1, FAULT_DCS);
   endtask

   task automatic test_register_extremes();
      drain();
      write_csr(2'd3, 8'($urandom));
      write_csr(CSR_WANT_STATUS, 8'hFE);
      write_csr(CSR_BUF_CAP, 8'hFF);
      write_csr(CSR_FRAME_ID, 8'hFF);
      send_frame(253, FAULT_NONE);
   endtask

   task automatic test_random_traffic();
      int          stop_at, pick, n;
      frame_fault_type fault;
      stop_at = bytes_sent + RANDOM_ITEMS;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            drain();
            write_csr(CSR_WANT_STATUS, 8'($urandom));
            pick = $urandom_range(0, 9);
            write_csr(CSR_BUF_CAP, pick < 4 ? 8'hFF : pick < 6 ? 8'($urandom) :
                                   pick < 9 ? 8'($urandom_range(0, 8)) : 8'h00);
            pick = $urandom_range(0, 3);
            write_csr(CSR_FRAME_ID, pick == 0 ? 8'h00 : pick == 1 ? 8'hFF :
                                    pick == 2 ? RESET_FRAME_ID : 8'($urandom));
            if ($urandom_range(0, 3) == 0) write_csr(2'd3, 8'($urandom));
         end else if (pick < 70) begin
            pick = $urandom_range(0, 99);
            n = pick < 85 ? $urandom_range(0, 8) : pick < 95 ? $urandom_range(9, 40) :
                $urandom_range(41, 253 - int'(cfg_want));
            pick = $urandom_range(0, 39);
            fault = pick < 28 ? FAULT_NONE : pick < 31 ? FAULT_LCS : pick < 34 ? FAULT_TFI :
                    pick < 37 ? FAULT_SHORT : FAULT_DCS;
            send_frame(n, fault);
         end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
         end
      end
   endtask

   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(50, 300);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         0: rsp_ready = 1'b1;
         1: rsp_ready = 1'($urandom_range(0, 1));
         2: rsp_ready = (cycle_count % 4 == 0);
         default: begin
            if (hold_left == 0) begin
               rsp_ready = ~rsp_ready;
               hold_left = $urandom_range(1, 12);
            end else begin
               hold_left--;
            end
         end
      endcase
   end

   always @(posedge clock) begin : result_check
      rsp_item_type seen, exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.data_byte      = rsp_data_byte;
         seen.byte_index     = rsp_byte_index;
         seen.is_end         = rsp_is_end;
         seen.frame_status   = rsp_frame_status;
         seen.device_status  = rsp_device_status;
         seen.payload_length = rsp_payload_length;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result %p", seen));
         end else begin
            exp_r = pending_results.pop_front();
            if (exp_r.is_end) begin
               case (exp_r.frame_status)
                  ST_OK:   n_ok++;
                  ST_SIZE: n_size++;
                  default: n_comm++;
               endcase
            end else begin
               n_data++;
            end
            if (seen.data_byte != exp_r.data_byte)
               report_mismatch($sformatf("data_byte %h, expected %h",
                                         seen.data_byte, exp_r.data_byte));
            if (seen.byte_index != exp_r.byte_index)
               report_mismatch($sformatf("byte_index %0d, expected %0d",
                                         seen.byte_index, exp_r.byte_index));
            if (seen.is_end != exp_r.is_end)
               report_mismatch($sformatf("is_end %b, expected %b",
                                         seen.is_end, exp_r.is_end));
            if (seen.frame_status != exp_r.frame_status)
               report_mismatch($sformatf("frame_status %0d, expected %0d",
                                         seen.frame_status, exp_r.frame_status));
            if (seen.device_status != exp_r.device_status)
               report_mismatch($sformatf("device_status %h, expected %h",
                                         seen.device_status, exp_r.device_status));
            if (seen.payload_length != exp_r.payload_length)
               report_mismatch($sformatf("payload_length %0d, expected %0d",
                                         seen.payload_length, exp_r.payload_length));
         end
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = '0;
      rsp_ready   = 1'b0;
      csr_write   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      cfg_want    = 1'b0;
      cfg_cap     = RESET_BUF_CAP;
      cfg_fid     = RESET_FRAME_ID;
      back_to_hunt();
      repeat (8) @(negedge clock);
      reset = 1'b0;

      test_default_frames();
      test_start_hunting();
      test_header_faults();
      test_status_and_capacity();
      test_data_checksum();
      test_register_extremes();
      test_random_traffic();

      drain();
      repeat (8) @(negedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      $display("%0d bytes in %0d frames; %0d payload bytes, %0d ok, %0d comm errors, %0d too long",
               bytes_sent, n_frames, n_data, n_ok, n_comm, n_size);
      $display("%0d mismatches in %0d cycles", fails, cycle_count);
      if (fails == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
